@@ rtl/core/smgd_pkg.sv @@
// ----------------------------------------------------------------------------
// smgd_pkg: shared types and helpers for the symbol Gray map / deinterleaver
// Payload structs, the block descriptor handed from front to back, the
// configuration view and the rotate-within-width helper.
// ----------------------------------------------------------------------------
package smgd_pkg;

	// Spreading factor limits and the reduced-rate threshold
	localparam int MIN_SF       = 7;
	localparam int MAX_SF       = 12;
	localparam int REDUCE_ABOVE = 10;

	// Block geometry
	localparam int MAX_BLK  = 8;
	localparam int WORD_W   = 12;
	localparam int BYTE_W   = 8;
	localparam int ROW_W    = 4;
	localparam int CNT_W    = 4;
	localparam int SF_W     = 4;
	localparam int CR_W     = 3;
	localparam int BASE_BLK = 4;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_SF = 1'b0;
	localparam logic REG_CR = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] symbol_bin;
		logic              header_symbol;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] deinterleaved_word;
		logic [ROW_W-1:0]  row_index;
		logic              last;
	} result_t;

	// Effective configuration seen by the front
	typedef struct packed {
		logic [SF_W-1:0]  sf;
		logic [CNT_W-1:0] blk_len;
	} cfg_t;

	// One closed block: Gray words, word count and codeword count
	typedef struct packed {
		logic [MAX_BLK-1:0][WORD_W-1:0] words;
		logic [CNT_W-1:0]               n;
		logic [SF_W-1:0]                ppm;
	} blk_t;

	// Rotate v left by n within size bits; bits at and above size read zero
	function automatic logic [WORD_W-1:0] rot_word(
		input logic [WORD_W-1:0] v,
		input logic [SF_W-1:0]   n,
		input logic [SF_W-1:0]   size
	);
		logic [WORD_W-1:0] r;
		logic [SF_W:0]     src;
		logic [SF_W-1:0]   bb;
		r = '0;
		for (int b = 0; b < WORD_W; b++) begin
			bb  = SF_W'(b);
			src = '0;
			if (bb < size) begin
				if (bb >= n) begin
					src = {1'b0, bb} - {1'b0, n};
				end else begin
					src = {1'b0, bb} + {1'b0, size} - {1'b0, n};
				end
				r[b] = v[src[SF_W-1:0]];
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/core/smgd_front.sv @@
// ----------------------------------------------------------------------------
// smgd_front: symbol intake
// Masks and optionally reduces each bin, Gray maps it into the word store
// and hands a finished block to the descriptor queue.
// ----------------------------------------------------------------------------
module smgd_front #(
	parameter int MAX_BLOCK_SYMBOLS = smgd_pkg::MAX_BLK
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smgd_pkg::cfg_t       cfg,
	input  logic                 push,
	output logic                 full,
	input  smgd_pkg::item_t      item,
	output logic                 dq_push,
	output smgd_pkg::blk_t       dq_data,
	input  logic                 dq_full
);

	localparam int IDX_W = $clog2(MAX_BLOCK_SYMBOLS);
	localparam int WW    = smgd_pkg::WORD_W;
	localparam int CW    = smgd_pkg::CNT_W;
	localparam int SW    = smgd_pkg::SF_W;

	logic [WW-1:0] store_q [MAX_BLOCK_SYMBOLS];
	logic [CW-1:0] wcnt_q;

	logic          reduced;
	logic [WW-1:0] sf_mask;
	logic [WW-1:0] bin;
	logic [WW:0]   rsum;
	logic [WW-1:0] rbin;
	logic [WW-1:0] sel_bin;
	logic [WW-1:0] gray;
	logic [SW-1:0] ppm;
	logic [CW-1:0] wcnt_inc;
	logic          closes;
	logic          acc;

	// Bin reduction and Gray mapping
	always_comb begin
		reduced = item.header_symbol || (cfg.sf > SW'(smgd_pkg::REDUCE_ABOVE));
		sf_mask = (WW'(1) << cfg.sf) - WW'(1);
		bin     = item.symbol_bin & sf_mask;
		rsum    = {1'b0, bin} + (WW+1)'(2);
		rbin    = WW'(rsum[WW:2]) & (sf_mask >> 2);
		sel_bin = reduced ? rbin : bin;
		gray    = sel_bin ^ (sel_bin >> 1);
		ppm     = reduced ? (cfg.sf - SW'(2)) : cfg.sf;
	end

	// Block close; stall only a closing symbol that finds the queue full
	assign wcnt_inc = wcnt_q + CW'(1);
	assign closes   = (wcnt_inc >= cfg.blk_len);
	assign full     = closes && dq_full;
	assign acc      = push && !full;
	assign dq_push  = acc && closes;

	// Descriptor: stored words with the closing word in its slot
	always_comb begin
		dq_data.words = '0;
		for (int i = 0; i < smgd_pkg::MAX_BLK; i++) begin
			if (i < MAX_BLOCK_SYMBOLS) begin
				if (CW'(i) == wcnt_q) begin
					dq_data.words[i] = gray;
				end else begin
					dq_data.words[i] = store_q[IDX_W'(i)];
				end
			end
		end
		dq_data.n   = wcnt_inc;
		dq_data.ppm = ppm;
	end

	// Word store (no reset; unwritten slots pass on but the back clears them)
	always_ff @(posedge clk) begin
		if (acc) begin
			store_q[wcnt_q[IDX_W-1:0]] <= gray;
		end
	end

	// Word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
		end else if (acc) begin
			wcnt_q <= closes ? '0 : wcnt_inc;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q < CW'(MAX_BLOCK_SYMBOLS))
		else $error("word count past store depth");

	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> dq_full)
		else $error("intake stalled with room in descriptor queue");

	a_close_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && closes) |=> (wcnt_q == '0))
		else $error("word count not cleared after block close");

endmodule

@@ rtl/core/smgd_dq.sv @@
// ----------------------------------------------------------------------------
// smgd_dq: block descriptor queue
// Two-entry queue of closed blocks between the front and the back.
// ----------------------------------------------------------------------------
module smgd_dq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  smgd_pkg::blk_t din,
	output logic           full,
	input  logic           pop,
	output smgd_pkg::blk_t dout,
	output logic           empty
);

	smgd_pkg::blk_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/core/smgd_back.sv @@
// ----------------------------------------------------------------------------
// smgd_back: codeword generator
// Loads a block, rotates each word by its position within ppm bits, reads
// one codeword column per cycle into a two-entry result queue while not full.
// ----------------------------------------------------------------------------
module smgd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              dq_empty,
	input  smgd_pkg::blk_t    dq_data,
	output logic              dq_pop,
	output logic              empty,
	input  logic              pop,
	output smgd_pkg::result_t result
);

	localparam int NB = smgd_pkg::MAX_BLK;
	localparam int WW = smgd_pkg::WORD_W;
	localparam int SW = smgd_pkg::SF_W;
	localparam int RW = smgd_pkg::ROW_W;
	localparam int CW = smgd_pkg::CNT_W;

	logic              busy_q;
	logic [RW-1:0]     x_q;
	logic [SW-1:0]     ppm_q;
	logic [WW-1:0]     rot_q [NB];

	smgd_pkg::result_t ofifo_q [2];
	logic              owr_q;
	logic              ord_q;
	logic [1:0]        ocnt_q;

	logic [WW-1:0]     rot_d [NB];
	logic [SW-1:0]     rot_n;
	logic              o_full;
	logic              emit;
	logic              is_last;
	logic              emit_last;
	logic              o_pop;
	smgd_pkg::result_t row_d;

	// Rotation of each word of the incoming block; unused slots cleared
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			rot_n = (SW'(i) >= dq_data.ppm) ? (SW'(i) - dq_data.ppm) : SW'(i);
			if (CW'(i) < dq_data.n) begin
				rot_d[i] = smgd_pkg::rot_word(dq_data.words[i], rot_n, dq_data.ppm);
			end else begin
				rot_d[i] = '0;
			end
		end
	end

	// Row sequencing
	assign o_full    = (ocnt_q == 2'd2);
	assign emit      = busy_q && !o_full;
	assign is_last   = (x_q == (ppm_q - SW'(1)));
	assign emit_last = emit && is_last;
	assign dq_pop    = !dq_empty && (!busy_q || emit_last);

	// Column pick for the current row
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			row_d.deinterleaved_word[i] = rot_q[i][x_q];
		end
		row_d.row_index = x_q;
		row_d.last      = is_last;
	end

	// Rotated block (payload)
	always_ff @(posedge clk) begin
		if (dq_pop) begin
			rot_q <= rot_d;
			ppm_q <= dq_data.ppm;
		end
	end

	// Row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			x_q    <= '0;
		end else if (dq_pop) begin
			busy_q <= 1'b1;
			x_q    <= '0;
		end else if (emit_last) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			x_q <= x_q + RW'(1);
		end
	end

	// Result queue
	assign empty  = (ocnt_q == 2'd0);
	assign o_pop  = pop && !empty;
	assign result = ofifo_q[ord_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			ofifo_q[owr_q] <= row_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (emit) begin
				owr_q <= ~owr_q;
			end
			if (o_pop) begin
				ord_q <= ~ord_q;
			end
			if (emit && !o_pop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (o_pop && !emit) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (x_q < RW'(ppm_q)))
		else $error("row index past codeword count");

	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result queue overfilled");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> (!busy_q || (x_q == '0)))
		else $error("row counter did not restart after last codeword");

endmodule

@@ rtl/core/symbol_gray_map_deinterleave_top.sv @@
// ----------------------------------------------------------------------------
// symbol_gray_map_deinterleave_top: symbol Gray mapping and deinterleaving
// Collects Gray-mapped chirp bins into blocks of 4+cr symbols, capped at
// MAX_BLOCK_SYMBOLS; emits each block's diagonally deinterleaved codewords.
//
//   channel  direction  handshake             payload
//   item     in         push / full           item_t   (symbol_bin, header)
//   result   out        pop / empty           result_t (word, row, last)
//   config   in         psel/penable/pwrite   pwdata, paddr (sf @0, cr @4)
//
// One symbol is accepted per cycle unless full. A block of ppm codewords
// (5..10) leaves at one codeword per cycle while popped; intake or readout,
// the slower, is the limit. It passes the descriptor queue, rotated block
// and result queue. full rises only for a closing symbol while two closed
// blocks are pending. Reset is immediate; the word store is not cleared.
// ----------------------------------------------------------------------------
module symbol_gray_map_deinterleave_top #(
	parameter int MAX_SPREADING     = smgd_pkg::MAX_SF,
	parameter int MAX_BLOCK_SYMBOLS = smgd_pkg::MAX_BLK
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  smgd_pkg::item_t               item,
	output logic                          empty,
	input  logic                          pop,
	output smgd_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smgd_pkg::APB_AW-1:0]   paddr,
	input  logic [smgd_pkg::APB_DW-1:0]   pwdata,
	output logic [smgd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int SW = smgd_pkg::SF_W;
	localparam int RW = smgd_pkg::CR_W;
	localparam int CW = smgd_pkg::CNT_W;
	localparam int DW = smgd_pkg::APB_DW;

	logic [SW-1:0]  sf_q;
	logic [RW-1:0]  cr_q;
	logic           wr_en;
	logic [CW-1:0]  len_sum;
	smgd_pkg::cfg_t cfg;

	logic           dq_push;
	logic           dq_full;
	logic           dq_pop;
	logic           dq_empty;
	smgd_pkg::blk_t dq_in;
	smgd_pkg::blk_t dq_out;

	// Register port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q <= SW'(7);
			cr_q <= RW'(4);
		end else if (wr_en) begin
			unique case (paddr[2])
				smgd_pkg::REG_SF: sf_q <= pwdata[SW-1:0];
				smgd_pkg::REG_CR: cr_q <= pwdata[RW-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			smgd_pkg::REG_SF: prdata = DW'(sf_q);
			smgd_pkg::REG_CR: prdata = DW'(cr_q);
		endcase
	end

	// Effective spreading factor and block length
	always_comb begin
		if (sf_q < SW'(smgd_pkg::MIN_SF)) begin
			cfg.sf = SW'(smgd_pkg::MIN_SF);
		end else if (sf_q > SW'(MAX_SPREADING)) begin
			cfg.sf = SW'(MAX_SPREADING);
		end else begin
			cfg.sf = sf_q;
		end
		len_sum = CW'(smgd_pkg::BASE_BLK) + CW'(cr_q);
		if (len_sum > CW'(MAX_BLOCK_SYMBOLS)) begin
			cfg.blk_len = CW'(MAX_BLOCK_SYMBOLS);
		end else begin
			cfg.blk_len = len_sum;
		end
	end

	smgd_front #(
		.MAX_BLOCK_SYMBOLS(MAX_BLOCK_SYMBOLS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.push    (push),
		.full    (full),
		.item    (item),
		.dq_push (dq_push),
		.dq_data (dq_in),
		.dq_full (dq_full)
	);

	smgd_dq u_dq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dq_push),
		.din    (dq_in),
		.full   (dq_full),
		.pop    (dq_pop),
		.dout   (dq_out),
		.empty  (dq_empty)
	);

	smgd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.dq_empty (dq_empty),
		.dq_data  (dq_out),
		.dq_pop   (dq_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for symbol_gray_map_deinterleave_top
// Drives symbols through the push/full queue port and configures spreading
// factor and coding rate over APB between phases. A scoreboard predicts the
// deinterleaved codewords of each closed block and checks every popped
// codeword field by field. Directed blocks come first, then random phases
// with varied configuration and sender/receiver idling.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT  = 800000;
	localparam int SETTLE_WAIT  = 24;
	localparam int PHASE_ITEMS  = 49;
	localparam int RAND_PHASES  = 8;
	localparam int MAX_PRINTS   = 40;

	// Predicts codewords from accepted symbols and checks popped codewords
	class deint_scoreboard;
		bit [smgd_pkg::SF_W-1:0]   sf_reg;
		bit [smgd_pkg::CR_W-1:0]   cr_reg;
		bit [smgd_pkg::WORD_W-1:0] gray_words[smgd_pkg::MAX_BLK];
		bit [smgd_pkg::CNT_W-1:0]  word_count;
		smgd_pkg::result_t         codeword_q[$];
		int                        errors;

		function new();
			sf_reg     = 4'd7;
			cr_reg     = 3'd4;
			word_count = '0;
			errors     = 0;
			foreach (gray_words[k]) gray_words[k] = '0;
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(logic reg_idx, logic [smgd_pkg::APB_DW-1:0] value);
			if (reg_idx == smgd_pkg::REG_SF) sf_reg = value[smgd_pkg::SF_W-1:0];
			else cr_reg = value[smgd_pkg::CR_W-1:0];
		endfunction

		function int open_words();
			return word_count;
		endfunction

		function int pending();
			return codeword_q.size();
		endfunction

		// Gray map one symbol into the open block; close the block when full
		function void note_symbol(smgd_pkg::item_t sym);
			int unsigned       s, blk_len, ppm, b, mask, w, n;
			bit                reduced;
			bit [7:0]          cw;
			smgd_pkg::result_t r;
			s = sf_reg;
			if (s < smgd_pkg::MIN_SF) s = smgd_pkg::MIN_SF;
			if (s > smgd_pkg::MAX_SF) s = smgd_pkg::MAX_SF;
			reduced = sym.header_symbol || (s > smgd_pkg::REDUCE_ABOVE);
			b = sym.symbol_bin & ((1 << s) - 1);
			blk_len = smgd_pkg::BASE_BLK + cr_reg;
			if (blk_len > smgd_pkg::MAX_BLK) blk_len = smgd_pkg::MAX_BLK;
			if (reduced) b = ((b + 2) >> 2) & ((1 << (s - 2)) - 1);
			if (word_count >= smgd_pkg::MAX_BLK) word_count = '0;
			gray_words[word_count] = smgd_pkg::WORD_W'(b ^ (b >> 1));
			word_count++;
			if (word_count < blk_len) return;
			// column x of the block, word i rotated left by i within ppm bits
			ppm  = reduced ? s - 2 : s;
			mask = (1 << ppm) - 1;
			for (int unsigned x = 0; x < ppm; x++) begin
				cw = '0;
				for (int unsigned i = 0; i < word_count; i++) begin
					n = i % ppm;
					w = gray_words[i] & mask;
					if (n != 0) w = ((w << n) & mask) | (w >> (ppm - n));
					cw[i] = w[x];
				end
				r.deinterleaved_word = cw;
				r.row_index          = smgd_pkg::ROW_W'(x);
				r.last               = (x == ppm - 1);
				codeword_q = {codeword_q, r};
			end
			word_count = '0;
		endfunction

		task check_codeword(smgd_pkg::result_t got);
			smgd_pkg::result_t want;
			if (codeword_q.size() == 0) begin
				report($sformatf("unexpected codeword %02h row %0d",
					got.deinterleaved_word, got.row_index));
				return;
			end
			want = codeword_q.pop_front();
			if (got.deinterleaved_word !== want.deinterleaved_word)
				report($sformatf("row %0d word %02h, want %02h", want.row_index,
					got.deinterleaved_word, want.deinterleaved_word));
			if (got.row_index !== want.row_index)
				report($sformatf("row_index %0d, want %0d", got.row_index, want.row_index));
			if (got.last !== want.last)
				report($sformatf("row %0d last %b, want %b", want.row_index,
					got.last, want.last));
		endtask
	endclass

	logic                        clk     = 1'b0;
	logic                        arst_n  = 1'b0;
	logic                        push    = 1'b0;
	logic                        full;
	smgd_pkg::item_t             item    = '0;
	logic                        empty;
	logic                        pop     = 1'b0;
	smgd_pkg::result_t           result;
	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [smgd_pkg::APB_AW-1:0] paddr   = '0;
	logic [smgd_pkg::APB_DW-1:0] pwdata  = '0;
	logic [smgd_pkg::APB_DW-1:0] prdata;
	logic                        pready;

	deint_scoreboard sb;
	int unsigned     gap_pct     = 0;
	int unsigned     stall_pct   = 0;
	int unsigned     cycle_count = 0;

	symbol_gray_map_deinterleave_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Result side: check each popped codeword, stall at random
	always @(posedge clk) begin
		if (arst_n && pop && !empty) sb.check_codeword(result);
		pop <= ($urandom_range(99) >= stall_pct);
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** symbol_gray_map_deinterleave_top: FAILED **");
			$finish;
		end
	end

	// One symbol transfer; push stays high into the next call when there is no gap
	task send_symbol(smgd_pkg::item_t sym);
		if ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		push <= 1'b1;
		item <= sym;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_symbol(sym);
	endtask

	// APB write: setup then access; upper data bits carry noise
	task apb_write(logic reg_idx, int unsigned value);
		logic [smgd_pkg::APB_DW-1:0] data;
		data = $urandom;
		if (reg_idx == smgd_pkg::REG_SF) data[smgd_pkg::SF_W-1:0] = value[smgd_pkg::SF_W-1:0];
		else data[smgd_pkg::CR_W-1:0] = value[smgd_pkg::CR_W-1:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(reg_idx, data);
	endtask

	task apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stop pushing, wait for every predicted codeword, then let the pipe settle
	task drain();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task configure(int unsigned sf, int unsigned cr);
		apb_write(smgd_pkg::REG_SF, sf);
		apb_write(smgd_pkg::REG_CR, cr);
		apb_release();
	endtask

	initial begin
		int unsigned     phase_sf[RAND_PHASES];
		int unsigned     phase_cr[RAND_PHASES];
		smgd_pkg::item_t sym;
		bit              blk_hdr;
		phase_sf = '{7, 12, 10, 11, 15, 9, 8, 12};
		phase_cr = '{1, 4, 0, 7, 3, 2, 6, 4};
		sb = new();
		blk_hdr = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme bins in a full-length block at the smallest sf
		configure(7, 4);
		send_symbol(smgd_pkg::item_t'{12'h000, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'hFFF, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'h07F, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'h001, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'h002, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'h07E, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'hAAA, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'h555, 1'b0});
		drain();

		// Directed: largest sf forces reduced rate, coding rate zero
		configure(12, 0);
		send_symbol(smgd_pkg::item_t'{12'hFFF, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'hFFE, 1'b1});
		send_symbol(smgd_pkg::item_t'{12'h002, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'h001, 1'b1});
		drain();

		// Directed: sf below range, block longer than store, mixed header flags,
		// then coding rate lowered while the block is open
		configure(0, 7);
		send_symbol(smgd_pkg::item_t'{12'hFFF, 1'b1});
		send_symbol(smgd_pkg::item_t'{12'h000, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'h07F, 1'b1});
		send_symbol(smgd_pkg::item_t'{12'h07F, 1'b0});
		send_symbol(smgd_pkg::item_t'{12'h001, 1'b1});
		send_symbol(smgd_pkg::item_t'{12'h003, 1'b0});
		drain();
		apb_write(smgd_pkg::REG_CR, 1);
		apb_release();
		send_symbol(smgd_pkg::item_t'{12'hFFE, 1'b1});
		drain();

		// Random phases: mostly blocks with one header flag, some mixed
		for (int p = 0; p < RAND_PHASES; p++) begin
			configure(phase_sf[p], phase_cr[p]);
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 81; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 81; end
				default: begin gap_pct = 20; stall_pct = 20; end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (sb.open_words() == 0) blk_hdr = ($urandom_range(2) == 0);
				case ($urandom_range(7))
					0: sym.symbol_bin = 12'h000;
					1: sym.symbol_bin = 12'hFFF;
					default: sym.symbol_bin = 12'($urandom);
				endcase
				sym.header_symbol = ($urandom_range(15) == 0) ? !blk_hdr : blk_hdr;
				send_symbol(sym);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** symbol_gray_map_deinterleave_top: PASSED **");
		end else begin
			$display("** symbol_gray_map_deinterleave_top: FAILED **");
		end
		$finish;
	end

endmodule

@@ symbol_gray_map_deinterleave_top.f @@
rtl/core/smgd_pkg.sv
rtl/core/smgd_front.sv
rtl/core/smgd_dq.sv
rtl/core/smgd_back.sv
rtl/core/symbol_gray_map_deinterleave_top.sv
sim/tb.sv
